@@ design/dqme_pkg.sv @@
package dqme_pkg;

   localparam int POS_W    = 13;
   localparam int STEP_W   = 5;
   localparam int ADDR_W   = 9;
   localparam int DATA_W   = 8;
   localparam int CSR_AW   = 1;
   localparam int CSR_DW   = 16;

   localparam logic [7:0] DOT_CHAR = 8'h2E;

   localparam logic [CSR_AW-1:0] REG_QUERY_TYPE     = 1'd0;
   localparam logic [CSR_AW-1:0] REG_TRANSACTION_ID = 1'd1;

   // write steps of one command
   localparam logic [STEP_W-1:0] STEP_TID_HI   = 5'd0;
   localparam logic [STEP_W-1:0] STEP_TID_LO   = 5'd1;
   localparam logic [STEP_W-1:0] STEP_FLAGS    = 5'd2;
   localparam logic [STEP_W-1:0] STEP_QDCOUNT  = 5'd5;
   localparam logic [STEP_W-1:0] STEP_HDR_LAST = 5'd11;
   localparam logic [STEP_W-1:0] STEP_MID      = 5'd12;
   localparam logic [STEP_W-1:0] STEP_LEN      = 5'd13;
   localparam logic [STEP_W-1:0] STEP_ROOT     = 5'd14;
   localparam logic [STEP_W-1:0] STEP_TYPE_LO  = 5'd16;
   localparam logic [STEP_W-1:0] STEP_CLASS_LO = 5'd18;

   typedef struct packed {
      logic              hdr;
      logic [15:0]       tid;
      logic              has_mid;
      logic [POS_W-1:0]  mid_addr;
      logic [7:0]        mid_byte;
      logic              fin;
      logic [POS_W-1:0]  trail_llp;
      logic [7:0]        trail_len;
      logic [POS_W-1:0]  trail_x;
      logic [7:0]        qtype;
   } cmd_type;

endpackage

@@ design/dqme_front.sv @@
module dqme_front #(
   parameter int MSG_BYTES = 512
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [7:0]                    req_tdata,   // name_char
   input  logic                          req_tlast,   // final_char
   input  logic                          csr_we,
   input  logic [dqme_pkg::CSR_AW-1:0]   csr_addr,
   input  logic [dqme_pkg::CSR_DW-1:0]   csr_wdata,
   input  logic                          q_full,
   output logic                          q_push,
   output dqme_pkg::cmd_type             q_cmd
);
   import dqme_pkg::*;

   localparam logic [POS_W-1:0] MSG_POS = POS_W'(MSG_BYTES);
   localparam logic [POS_W-1:0] LLP_RST = POS_W'(12);
   localparam logic [POS_W-1:0] WP_RST  = POS_W'(13);

   logic [7:0]       qtype_ff, qtype_in;
   logic [15:0]      tid_ff, tid_in;
   logic             in_msg_ff, in_msg_in;
   logic [POS_W-1:0] llp_ff, llp_in;
   logic [POS_W-1:0] wp_ff, wp_in;

   logic             is_dot;
   logic [POS_W-1:0] llp_nx, wp_nx, wp_bump, len_full, tlen_full;

   assign req_tready = !q_full;
   assign q_push     = req_tvalid && !q_full;
   assign is_dot     = (req_tdata == DOT_CHAR);
   assign wp_bump    = (wp_ff < MSG_POS) ? wp_ff + POS_W'(1) : MSG_POS;
   assign len_full   = wp_ff - llp_ff - POS_W'(1);

   always_comb begin
      llp_nx = llp_ff;
      wp_nx  = wp_ff;
      if (is_dot) begin
         if (!req_tlast) begin
            llp_nx = wp_ff;
            wp_nx  = wp_bump;
         end
      end else begin
         wp_nx = wp_bump;
      end
   end

   assign tlen_full = wp_nx - llp_nx - POS_W'(1);

   always_comb begin
      q_cmd           = '0;
      q_cmd.hdr       = !in_msg_ff;
      q_cmd.tid       = tid_ff;
      q_cmd.has_mid   = !(is_dot && req_tlast);
      q_cmd.mid_addr  = is_dot ? llp_ff : wp_ff;
      q_cmd.mid_byte  = is_dot ? len_full[7:0] : req_tdata;
      q_cmd.fin       = req_tlast;
      q_cmd.trail_llp = llp_nx;
      q_cmd.trail_len = tlen_full[7:0];
      q_cmd.trail_x   = wp_nx;
      q_cmd.qtype     = qtype_ff;
   end

   always_comb begin
      qtype_in  = qtype_ff;
      tid_in    = tid_ff;
      in_msg_in = in_msg_ff;
      llp_in    = llp_ff;
      wp_in     = wp_ff;
      if (csr_we) begin
         unique case (csr_addr)
            REG_QUERY_TYPE:     qtype_in = csr_wdata[7:0];
            REG_TRANSACTION_ID: tid_in   = csr_wdata;
            default: ;
         endcase
      end
      if (q_push) begin
         if (req_tlast) begin
            in_msg_in = 1'b0;
            llp_in    = LLP_RST;
            wp_in     = WP_RST;
         end else begin
            in_msg_in = 1'b1;
            llp_in    = llp_nx;
            wp_in     = wp_nx;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         qtype_ff  <= 8'd1;
         tid_ff    <= 16'd1;
         in_msg_ff <= 1'b0;
         llp_ff    <= LLP_RST;
         wp_ff     <= WP_RST;
      end else begin
         qtype_ff  <= qtype_in;
         tid_ff    <= tid_in;
         in_msg_ff <= in_msg_in;
         llp_ff    <= llp_in;
         wp_ff     <= wp_in;
      end
   end

endmodule

@@ design/dqme_queue.sv @@
module dqme_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  dqme_pkg::cmd_type push_cmd,
   output logic              full,
   input  logic              pop,
   output logic              empty,
   output dqme_pkg::cmd_type head
);
   import dqme_pkg::*;

   localparam int DEPTH = 2;

   cmd_type    mem_ff [DEPTH];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   assign full  = (count_ff == 2'(DEPTH));
   assign empty = (count_ff == 2'd0);
   assign head  = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

@@ design/dqme_back.sv @@
module dqme_back #(
   parameter int MSG_BYTES = 512
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              q_empty,
   input  dqme_pkg::cmd_type q_head,
   output logic              q_pop,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [23:0]       rsp_tdata,   // write_addr, write_byte
   output logic [1:0]        rsp_tuser,   // overflow, message_done
   output logic              rsp_tlast    // run_end
);
   import dqme_pkg::*;

   localparam logic [POS_W-1:0] MSG_POS = POS_W'(MSG_BYTES);

   logic              valid_ff, valid_in;
   logic [ADDR_W-1:0] addr_ff, addr_in;
   logic [DATA_W-1:0] byte_ff, byte_in;
   logic              ovf_ff, ovf_in;
   logic              last_ff, last_in;
   logic              done_ff, done_in;
   logic              busy_ff, busy_in;
   logic [STEP_W-1:0] step_ff, step_in;

   logic              advance;
   logic [STEP_W-1:0] cur_step, start_step, next_step;
   logic              is_last;
   logic [POS_W-1:0]  waddr;
   logic [DATA_W-1:0] wbyte;

   assign advance = !q_empty && (!valid_ff || rsp_tready);
   assign q_pop   = advance && is_last;

   always_comb begin
      if (q_head.hdr) begin
         start_step = STEP_TID_HI;
      end else if (q_head.has_mid) begin
         start_step = STEP_MID;
      end else begin
         start_step = STEP_LEN;
      end
   end

   assign cur_step = busy_ff ? step_ff : start_step;

   always_comb begin
      next_step = cur_step + STEP_W'(1);
      is_last   = 1'b0;
      if (cur_step == STEP_HDR_LAST) begin
         if (q_head.has_mid) begin
            next_step = STEP_MID;
         end else if (q_head.fin) begin
            next_step = STEP_LEN;
         end else begin
            is_last = 1'b1;
         end
      end else if (cur_step == STEP_MID) begin
         is_last = !q_head.fin;
      end else if (cur_step == STEP_CLASS_LO) begin
         is_last = 1'b1;
      end
   end

   always_comb begin
      waddr = '0;
      wbyte = '0;
      if (cur_step <= STEP_HDR_LAST) begin
         waddr = POS_W'(cur_step);
         case (cur_step)
            STEP_TID_HI:  wbyte = q_head.tid[15:8];
            STEP_TID_LO:  wbyte = q_head.tid[7:0];
            STEP_FLAGS:   wbyte = 8'd1;
            STEP_QDCOUNT: wbyte = 8'd1;
            default:      wbyte = 8'd0;
         endcase
      end else if (cur_step == STEP_MID) begin
         waddr = q_head.mid_addr;
         wbyte = q_head.mid_byte;
      end else if (cur_step == STEP_LEN) begin
         waddr = q_head.trail_llp;
         wbyte = q_head.trail_len;
      end else begin
         waddr = q_head.trail_x + POS_W'(cur_step - STEP_ROOT);
         case (cur_step)
            STEP_TYPE_LO:  wbyte = q_head.qtype;
            STEP_CLASS_LO: wbyte = 8'd1;
            default:       wbyte = 8'd0;
         endcase
      end
   end

   always_comb begin
      valid_in = valid_ff && !rsp_tready;
      addr_in  = addr_ff;
      byte_in  = byte_ff;
      ovf_in   = ovf_ff;
      last_in  = last_ff;
      done_in  = done_ff;
      busy_in  = busy_ff;
      step_in  = step_ff;
      if (advance) begin
         valid_in = 1'b1;
         ovf_in   = (waddr >= MSG_POS);
         addr_in  = ovf_in ? '0 : waddr[ADDR_W-1:0];
         byte_in  = ovf_in ? '0 : wbyte;
         last_in  = is_last;
         done_in  = (cur_step == STEP_CLASS_LO);
         busy_in  = !is_last;
         step_in  = next_step;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         busy_ff  <= 1'b0;
         step_ff  <= '0;
      end else begin
         valid_ff <= valid_in;
         busy_ff  <= busy_in;
         step_ff  <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      addr_ff <= addr_in;
      byte_ff <= byte_in;
      ovf_ff  <= ovf_in;
      last_ff <= last_in;
      done_ff <= done_in;
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = {7'd0, byte_ff, addr_ff};
   assign rsp_tuser  = {done_ff, ovf_ff};
   assign rsp_tlast  = last_ff;

   a_done_is_last: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && done_ff) |-> last_ff)
      else $error("message_done without run_end");

   a_ovf_zero: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && ovf_ff) |-> (addr_ff == '0 && byte_ff == '0))
      else $error("suppressed write carries data");

   a_busy_has_cmd: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> !q_empty)
      else $error("sequencer busy with no queued command");

   a_step_range: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> (step_ff <= STEP_CLASS_LO && step_ff != STEP_TID_HI))
      else $error("sequencer step out of range");

endmodule

@@ design/dns_query_message_encoder.sv @@
// DNS query message encoder. Host name characters arrive one per transfer on
// req_ (tlast marks the final one); each produces byte writes on rsp_ that
// build the query message. The front stage keeps label and write positions
// and takes one character per cycle into a two-entry command queue while it
// has room; the back sequencer turns each command into its writes, one write
// per cycle through a registered output while rsp_ accepts them. A plain
// character or an inner dot produces one write, the first character of a
// message adds twelve header writes and the final one six trailer writes (a
// final dot writes nothing of its own), so an item produces from one to
// nineteen writes. The input stalls only when the queue holds two pending
// commands. Configuration writes on csr_ take effect from the next cycle.
module dns_query_message_encoder #(
   parameter int MSG_BYTES = 512
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [7:0]                    req_tdata,   // name_char
   input  logic                          req_tlast,   // final_char
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [23:0]                   rsp_tdata,   // write_addr[8:0], write_byte[16:9]
   output logic [1:0]                    rsp_tuser,   // overflow[0], message_done[1]
   output logic                          rsp_tlast,   // run_end
   input  logic                          csr_we,
   input  logic [dqme_pkg::CSR_AW-1:0]   csr_addr,
   input  logic [dqme_pkg::CSR_DW-1:0]   csr_wdata
);
   import dqme_pkg::*;

   logic    q_full, q_push, q_empty, q_pop;
   cmd_type q_cmd, q_head;

   dqme_front #(.MSG_BYTES(MSG_BYTES)) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata),
      .q_full     (q_full),
      .q_push     (q_push),
      .q_cmd      (q_cmd)
   );

   dqme_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_cmd (q_cmd),
      .full     (q_full),
      .pop      (q_pop),
      .empty    (q_empty),
      .head     (q_head)
   );

   dqme_back #(.MSG_BYTES(MSG_BYTES)) u_back (
      .clock      (clock),
      .reset      (reset),
      .q_empty    (q_empty),
      .q_head     (q_head),
      .q_pop      (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule
